// ----- sv/gaps_pkg.sv -----
// shared types, constants and key compare for the grid path search
package gaps_pkg;

  localparam int COST_W     = 28;
  localparam int CELL_W     = 12;
  localparam int COORD_W    = 6;
  localparam int DIM_W      = 7;
  localparam int WEIGHT_W   = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;
  localparam int LIN_W      = 2 * DIM_W;

  localparam logic [COST_W-1:0] COST_MAX = '1;
  localparam logic [DIM_W-1:0] DIM_MAX = 7'd64;
  localparam logic [DIM_W-1:0] DIM_MIN = 7'd1;

  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GOAL   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DIAG   = 3'd4;

  localparam logic [2:0] NB_LAST = 3'd7;

  typedef struct packed {
    logic [COST_W-1:0]  prio;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
  } heap_key_t;

  typedef struct packed {
    logic      push;
    logic      pop;
    logic      clear;
    heap_key_t key;
  } heap_cmd_t;

  typedef struct packed {
    logic      busy;
    heap_key_t top;
  } heap_stat_t;

  typedef struct packed {
    logic              reached;
    logic [CELL_W-1:0] pred;
    logic [COST_W-1:0] cost;
  } node_t;

  typedef enum logic [3:0] {
    S_IDLE, S_QRY, S_SIZE, S_DIV, S_CLEAR, S_INIT, S_LOOP,
    S_GOAL, S_CUR, S_NB, S_RD, S_RELAX, S_RES
  } ctl_state_t;

  typedef enum logic [2:0] {
    H_IDLE, H_UP_RD, H_UP_CMP, H_POP_RD, H_POP_LD, H_DN_RD, H_DN_CMP
  } heap_state_t;

  // row/col order equals row-major cell order inside the grid
  function automatic logic key_less(heap_key_t a, heap_key_t b);
    if (a.prio != b.prio) return a.prio < b.prio;
    return {a.row, a.col} < {b.row, b.col};
  endfunction

endpackage

// ----- sv/gaps_ram.sv -----
// generic ram, one write port and two registered read ports
module gaps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ----- sv/gaps_divider.sv -----
// serial restoring divider, cell index by grid width, one bit per cycle
module gaps_divider (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [gaps_pkg::CELL_W-1:0] dividend,
  input  logic [gaps_pkg::DIM_W-1:0]  divisor,
  output logic                       busy,
  output logic [gaps_pkg::CELL_W-1:0] quotient,
  output logic [gaps_pkg::DIM_W-1:0]  remainder
);
  import gaps_pkg::*;

  localparam int STEP_W = $clog2(CELL_W + 1);

  logic [STEP_W-1:0] steps;
  logic [DIM_W:0]    trial;

  always_comb trial = {remainder, quotient[CELL_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      steps <= '0;
    end else if (start) begin
      busy      <= 1'b1;
      steps     <= STEP_W'(CELL_W);
      remainder <= '0;
      quotient  <= dividend;
    end else if (busy) begin
      if (trial >= {1'b0, divisor}) begin
        remainder <= DIM_W'(trial - {1'b0, divisor});
        quotient  <= {quotient[CELL_W-2:0], 1'b1};
      end else begin
        remainder <= DIM_W'(trial);
        quotient  <= {quotient[CELL_W-2:0], 1'b0};
      end
      steps <= steps - STEP_W'(1);
      if (steps == STEP_W'(1)) busy <= 1'b0;
    end
  end

endmodule

// ----- sv/gaps_heap.sv -----
// frontier min-heap controller over a ram, sift up on push and sift down on pop
module gaps_heap #(
  parameter int HEAP_DEPTH = 16384
) (
  input  logic                             clk,
  input  logic                             rst,
  input  gaps_pkg::heap_cmd_t              cmd,
  output gaps_pkg::heap_stat_t             stat,
  output logic [$clog2(HEAP_DEPTH+1)-1:0]  count
);
  import gaps_pkg::*;

  localparam int HAW = $clog2(HEAP_DEPTH);
  localparam int CW  = $clog2(HEAP_DEPTH + 1);
  localparam int IW  = HAW + 2;
  localparam int KW  = $bits(heap_key_t);

  heap_state_t state, state_next;
  logic [HAW-1:0] k, k_next;
  logic [CW-1:0]  count_next;
  heap_key_t      e, e_next, top;

  logic           we;
  logic [HAW-1:0] waddr, raddr_a, raddr_b, up_idx;
  heap_key_t      wdata, rdata_a, rdata_b;
  logic [KW-1:0]  rd_a_bits, rd_b_bits;
  logic [IW-1:0]  l_idx, r_idx, cnt_ext;
  logic           l_ok, r_ok, l_win, r_win;
  heap_key_t      best;

  gaps_ram #(.WIDTH(KW), .DEPTH(HEAP_DEPTH)) u_heap_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .rdata_a (rd_a_bits),
    .raddr_b (raddr_b),
    .rdata_b (rd_b_bits)
  );

  always_comb begin
    rdata_a = rd_a_bits;
    rdata_b = rd_b_bits;
    cnt_ext = IW'(count);
    l_idx   = {1'b0, k, 1'b1};
    r_idx   = l_idx + IW'(1);
    up_idx  = (k - HAW'(1)) >> 1;
    l_ok    = l_idx < cnt_ext;
    r_ok    = r_idx < cnt_ext;
    l_win   = l_ok && key_less(rdata_a, e);
    best    = l_win ? rdata_a : e;
    r_win   = r_ok && key_less(rdata_b, best);
  end

  always_comb begin
    state_next = state;
    k_next     = k;
    e_next     = e;
    count_next = count;
    we         = 1'b0;
    waddr      = k;
    wdata      = e;
    raddr_a    = HAW'(l_idx);
    raddr_b    = HAW'(r_idx);
    unique case (state)
      H_IDLE: begin
        if (cmd.clear) begin
          count_next = '0;
        end else if (cmd.push) begin
          k_next     = HAW'(count);
          count_next = count + CW'(1);
          e_next     = cmd.key;
          state_next = H_UP_RD;
        end else if (cmd.pop) begin
          count_next = count - CW'(1);
          if (count > CW'(1)) state_next = H_POP_RD;
        end
      end
      H_UP_RD: begin
        raddr_a = up_idx;
        if (k == '0) begin
          we         = 1'b1;
          state_next = H_IDLE;
        end else begin
          state_next = H_UP_CMP;
        end
      end
      H_UP_CMP: begin
        raddr_a = up_idx;
        we      = 1'b1;
        if (key_less(e, rdata_a)) begin
          wdata      = rdata_a;
          k_next     = up_idx;
          state_next = H_UP_RD;
        end else begin
          state_next = H_IDLE;
        end
      end
      H_POP_RD: begin
        raddr_a    = HAW'(count);
        state_next = H_POP_LD;
      end
      H_POP_LD: begin
        e_next     = rdata_a;
        k_next     = '0;
        state_next = H_DN_RD;
      end
      H_DN_RD: begin
        if (!l_ok) begin
          we         = 1'b1;
          state_next = H_IDLE;
        end else begin
          state_next = H_DN_CMP;
        end
      end
      H_DN_CMP: begin
        we = 1'b1;
        if (r_win) begin
          wdata      = rdata_b;
          k_next     = HAW'(r_idx);
          state_next = H_DN_RD;
        end else if (l_win) begin
          wdata      = rdata_a;
          k_next     = HAW'(l_idx);
          state_next = H_DN_RD;
        end else begin
          state_next = H_IDLE;
        end
      end
      default: state_next = H_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= H_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
    k <= k_next;
    e <= e_next;
    if (we && waddr == '0) top <= wdata;
  end

  always_comb begin
    stat.busy = (state != H_IDLE);
    stat.top  = top;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cnt_ext <= IW'(HEAP_DEPTH))
    else $error("heap count beyond depth");

  a_push_count: assert property (@(posedge clk) disable iff (rst)
    (state == H_IDLE && !cmd.clear && cmd.push) |=> count == $past(count) + CW'(1))
    else $error("push did not grow the heap");

  a_write_live: assert property (@(posedge clk) disable iff (rst)
    we |-> IW'(waddr) < cnt_ext)
    else $error("heap write outside live entries");

endmodule

// ----- sv/grid_astar_path_search.sv -----
// top level of the grid a-star path search: control sequencer, weight and node rams
// loads may come back to back; a query answer is registered from the S_QRY state once the
// output is free, and no input is taken meanwhile. a search after the last load: sizing
// shrinks the height until the grid fits MAX_CELLS, dividers split start and goal into row and
// column, all node entries are cleared, then a popped cell's on-grid neighbours are relaxed.
// reset restores register defaults, empties the heap and makes every query read unreached.
module grid_astar_path_search #(
  parameter int MAX_CELLS   = 4096,
  parameter int HEAP_DEPTH  = 16384,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            mode,
  input  logic [gaps_pkg::CELL_W-1:0]     cell_req,
  input  logic [gaps_pkg::WEIGHT_W-1:0]   weight,
  input  logic                            last,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            search_done,
  output logic                            found,
  output logic                            overflow,
  output logic [gaps_pkg::COST_W-1:0]     goal_cost,
  output logic [gaps_pkg::CELL_W-1:0]     predecessor,
  output logic                            reached,
  input  logic                            cfg_we,
  input  logic [gaps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gaps_pkg::CFG_DATA_W-1:0] cfg_data
);
  import gaps_pkg::*;

  localparam int AW    = $clog2(MAX_CELLS);
  localparam int HCW   = $clog2(HEAP_DEPTH + 1);
  localparam int SUM_W = (WEIGHT_BITS > COST_W ? WEIGHT_BITS : COST_W) + 1;

  ctl_state_t state, state_next;

  logic [DIM_W-1:0]  grid_height, grid_width;
  logic [CELL_W-1:0] start_cell, goal_cell;
  logic              diagonal_moves;

  logic [DIM_W-1:0]   w_eff, h_eff, w_clamp, h_clamp;
  logic [LIN_W-1:0]   prod, top_lin, nb_lin;
  logic               too_big, sg_valid, searched;
  logic [COORD_W-1:0] start_row, start_col, goal_row, goal_col;
  logic [COORD_W-1:0] cur_row, cur_col, nb_row, nb_col, nr, ncl, dr, dc;
  logic [CELL_W-1:0]  cur_idx, nb_cell, q_cell, top_idx;
  logic [COST_W-1:0]  cost_cur, gcost, relax_cost, push_prio;
  logic [2:0]         n;
  logic [DIM_W-1:0]   heur, heur_c;
  logic [AW-1:0]      clr;
  logic               q_ok, cell_ok, out_free, out_load, search_ovf;
  logic               go_up, go_down, go_left, go_right, is_diag, nb_ok;
  logic               take, top_is_goal, heap_full;
  logic               goal_hit, srch_ovf;
  logic [SUM_W-1:0]   wsum;
  logic [COST_W:0]    psum;

  logic               div_start, div_busy_s, div_busy_g;
  logic [CELL_W-1:0]  start_q, goal_q;
  logic [DIM_W-1:0]   start_r, goal_r;

  heap_cmd_t          heap_cmd;
  heap_stat_t         heap_stat;
  logic [HCW-1:0]     heap_count;

  logic                   weight_we;
  logic [WEIGHT_BITS-1:0] wt_rdata;
  logic                   node_we;
  logic [AW-1:0]          node_waddr, node_raddr;
  node_t                  node_wdata, node_rdata;
  logic [$bits(node_t)-1:0] node_rd_bits;

  gaps_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(MAX_CELLS)) u_weight_ram (
    .clk     (clk),
    .we      (weight_we),
    .waddr   (AW'(cell_req)),
    .wdata   (WEIGHT_BITS'(weight)),
    .raddr_a (AW'(nb_cell)),
    .rdata_a (wt_rdata),
    .raddr_b ('0),
    .rdata_b ()
  );

  gaps_ram #(.WIDTH($bits(node_t)), .DEPTH(MAX_CELLS)) u_node_ram (
    .clk     (clk),
    .we      (node_we),
    .waddr   (node_waddr),
    .wdata   (node_wdata),
    .raddr_a (node_raddr),
    .rdata_a (node_rd_bits),
    .raddr_b ('0),
    .rdata_b ()
  );

  gaps_heap #(.HEAP_DEPTH(HEAP_DEPTH)) u_heap (
    .clk   (clk),
    .rst   (rst),
    .cmd   (heap_cmd),
    .stat  (heap_stat),
    .count (heap_count)
  );

  gaps_divider u_div_start (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (start_cell),
    .divisor   (w_eff),
    .busy      (div_busy_s),
    .quotient  (start_q),
    .remainder (start_r)
  );

  gaps_divider u_div_goal (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (goal_cell),
    .divisor   (w_eff),
    .busy      (div_busy_g),
    .quotient  (goal_q),
    .remainder (goal_r)
  );

  // datapath
  always_comb begin
    node_rdata = node_rd_bits;
    cell_ok    = 32'(cell_req) < MAX_CELLS;
    out_free   = !out_valid || out_ready;

    w_clamp = (grid_width == '0) ? DIM_MIN : (grid_width > DIM_MAX) ? DIM_MAX : grid_width;
    if (32'(w_clamp) > MAX_CELLS) w_clamp = DIM_W'(MAX_CELLS);
    h_clamp = (grid_height == '0) ? DIM_MIN : (grid_height > DIM_MAX) ? DIM_MAX : grid_height;

    prod    = LIN_W'(h_eff) * LIN_W'(w_eff);
    too_big = 32'(prod) > MAX_CELLS;

    top_lin     = LIN_W'(heap_stat.top.row) * LIN_W'(w_eff) + LIN_W'(heap_stat.top.col);
    top_idx     = CELL_W'(top_lin);
    top_is_goal = heap_stat.top.row == goal_row && heap_stat.top.col == goal_col;
    heap_full   = 32'(heap_count) >= HEAP_DEPTH;

    go_up = 1'b0; go_down = 1'b0; go_left = 1'b0; go_right = 1'b0; is_diag = 1'b0;
    unique case (n)
      3'd0: begin go_up = 1'b1; go_left = 1'b1; is_diag = 1'b1; end
      3'd1: go_up = 1'b1;
      3'd2: begin go_up = 1'b1; go_right = 1'b1; is_diag = 1'b1; end
      3'd3: go_left = 1'b1;
      3'd4: go_right = 1'b1;
      3'd5: begin go_down = 1'b1; go_left = 1'b1; is_diag = 1'b1; end
      3'd6: go_down = 1'b1;
      default: begin go_down = 1'b1; go_right = 1'b1; is_diag = 1'b1; end
    endcase
    nb_ok = (!is_diag || diagonal_moves)
         && (!go_up || cur_row != '0)
         && (!go_down || DIM_W'(cur_row) + DIM_W'(1) < h_eff)
         && (!go_left || cur_col != '0)
         && (!go_right || DIM_W'(cur_col) + DIM_W'(1) < w_eff);
    nr  = go_up ? cur_row - COORD_W'(1) : go_down ? cur_row + COORD_W'(1) : cur_row;
    ncl = go_left ? cur_col - COORD_W'(1) : go_right ? cur_col + COORD_W'(1) : cur_col;
    nb_lin = LIN_W'(nr) * LIN_W'(w_eff) + LIN_W'(ncl);

    dr = (nb_row > goal_row) ? nb_row - goal_row : goal_row - nb_row;
    dc = (nb_col > goal_col) ? nb_col - goal_col : goal_col - nb_col;
    heur_c = diagonal_moves ? DIM_W'((dr > dc) ? dr : dc) : DIM_W'(dr) + DIM_W'(dc);

    wsum       = SUM_W'(cost_cur) + SUM_W'(wt_rdata);
    relax_cost = (wsum > SUM_W'(COST_MAX)) ? COST_MAX : COST_W'(wsum);
    psum       = {1'b0, relax_cost} + (COST_W+1)'(heur);
    push_prio  = psum[COST_W] ? COST_MAX : psum[COST_W-1:0];
    take       = relax_cost < node_rdata.cost;
  end

  // sequencer
  always_comb begin
    state_next   = state;
    in_ready     = 1'b0;
    weight_we    = 1'b0;
    div_start    = 1'b0;
    out_load     = 1'b0;
    search_ovf   = 1'b0;
    heap_cmd     = '0;
    heap_cmd.key = '{prio: push_prio, row: nb_row, col: nb_col};
    node_we      = 1'b0;
    node_waddr   = AW'(nb_cell);
    node_wdata   = '{reached: 1'b1, pred: cur_idx, cost: relax_cost};
    node_raddr   = AW'(nb_cell);
    unique case (state)
      S_IDLE: begin
        in_ready   = 1'b1;
        node_raddr = AW'(cell_req);
        if (in_valid) begin
          if (mode) begin
            state_next = S_QRY;
          end else begin
            weight_we = cell_ok;
            if (last) state_next = S_SIZE;
          end
        end
      end
      S_QRY: begin
        node_raddr = AW'(q_cell);
        if (out_free) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_SIZE: begin
        if (!too_big) begin
          div_start  = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (!div_busy_s && !div_busy_g) begin
          heap_cmd.clear = 1'b1;
          state_next     = S_CLEAR;
        end
      end
      S_CLEAR: begin
        node_we    = 1'b1;
        node_waddr = clr;
        node_wdata = '{reached: 1'b0, pred: '0, cost: COST_MAX};
        if (clr == AW'(MAX_CELLS - 1)) state_next = S_INIT;
      end
      S_INIT: begin
        if (sg_valid) begin
          node_we       = 1'b1;
          node_waddr    = AW'(start_cell);
          node_wdata    = '{reached: 1'b0, pred: '0, cost: '0};
          heap_cmd.push = 1'b1;
          heap_cmd.key  = '{prio: '0, row: start_row, col: start_col};
          state_next    = S_LOOP;
        end else begin
          state_next = S_RES;
        end
      end
      S_LOOP: begin
        node_raddr = AW'(top_idx);
        if (!heap_stat.busy) begin
          if (heap_count == '0) begin
            state_next = S_RES;
          end else if (top_is_goal) begin
            state_next = S_GOAL;
          end else begin
            heap_cmd.pop = 1'b1;
            state_next   = S_CUR;
          end
        end
      end
      S_GOAL: state_next = S_RES;
      S_CUR:  state_next = S_NB;
      S_NB: begin
        if (nb_ok) state_next = S_RD;
        else if (n == NB_LAST) state_next = S_LOOP;
      end
      S_RD: state_next = S_RELAX;
      S_RELAX: begin
        if (!take) begin
          state_next = (n == NB_LAST) ? S_LOOP : S_NB;
        end else if (!heap_stat.busy) begin
          if (heap_full) begin
            search_ovf = 1'b1;
            state_next = S_RES;
          end else begin
            heap_cmd.push = 1'b1;
            node_we       = 1'b1;
            state_next    = (n == NB_LAST) ? S_LOOP : S_NB;
          end
        end
      end
      S_RES: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      out_valid      <= 1'b0;
      searched       <= 1'b0;
      grid_height    <= DIM_MAX;
      grid_width     <= DIM_MAX;
      start_cell     <= '0;
      goal_cell      <= '0;
      diagonal_moves <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (state == S_CLEAR) searched <= 1'b1;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_HEIGHT: grid_height    <= cfg_data[DIM_W-1:0];
          REG_WIDTH:  grid_width     <= cfg_data[DIM_W-1:0];
          REG_START:  start_cell     <= cfg_data;
          REG_GOAL:   goal_cell      <= cfg_data;
          REG_DIAG:   diagonal_moves <= cfg_data[0];
          default: ;
        endcase
      end
    end

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          q_cell   <= cell_req;
          q_ok     <= cell_ok;
          w_eff    <= w_clamp;
          h_eff    <= h_clamp;
          goal_hit <= 1'b0;
          srch_ovf <= 1'b0;
        end
      end
      S_SIZE:  if (too_big) h_eff <= h_eff - DIM_W'(1);
      S_DIV: begin
        sg_valid  <= (LIN_W'(start_cell) < prod) && (LIN_W'(goal_cell) < prod);
        start_row <= start_q[COORD_W-1:0];
        start_col <= start_r[COORD_W-1:0];
        goal_row  <= goal_q[COORD_W-1:0];
        goal_col  <= goal_r[COORD_W-1:0];
        clr       <= '0;
      end
      S_CLEAR: clr <= clr + AW'(1);
      S_LOOP: begin
        cur_row <= heap_stat.top.row;
        cur_col <= heap_stat.top.col;
        cur_idx <= top_idx;
      end
      S_GOAL: begin
        gcost    <= node_rdata.cost;
        goal_hit <= 1'b1;
      end
      S_CUR: begin
        cost_cur <= node_rdata.cost;
        n        <= '0;
      end
      S_NB: begin
        if (nb_ok) begin
          nb_row  <= nr;
          nb_col  <= ncl;
          nb_cell <= CELL_W'(nb_lin);
        end else begin
          n <= n + 3'd1;
        end
      end
      S_RD: heur <= heur_c;
      S_RELAX: begin
        if (search_ovf) srch_ovf <= 1'b1;
        else if (!take || !heap_stat.busy) n <= n + 3'd1;
      end
      default: ;
    endcase

    if (out_load) begin
      if (state == S_QRY) begin
        search_done <= 1'b0;
        found       <= 1'b0;
        overflow    <= 1'b0;
        goal_cost   <= '0;
        reached     <= searched && q_ok && node_rdata.reached;
        predecessor <= (searched && q_ok && node_rdata.reached) ? node_rdata.pred : '0;
      end else begin
        search_done <= 1'b1;
        found       <= goal_hit;
        overflow    <= srch_ovf;
        goal_cost   <= goal_hit ? gcost : COST_MAX;
        reached     <= 1'b0;
        predecessor <= '0;
      end
    end
  end

  a_push_idle: assert property (@(posedge clk) disable iff (rst)
    heap_cmd.push |-> !heap_stat.busy)
    else $error("push while heap busy");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    heap_cmd.push |-> 32'(heap_count) < HEAP_DEPTH)
    else $error("push into a full heap");

  a_relax_lower: assert property (@(posedge clk) disable iff (rst)
    (node_we && state == S_RELAX) |-> relax_cost < node_rdata.cost)
    else $error("relaxation without a lower cost");

  a_search_start: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !mode && last) |=> state == S_SIZE)
    else $error("last load did not start a search");

endmodule
